// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define APR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define APR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/apr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging page replacement package
// Shared widths, register indexes and the control state type.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int PAGE_W     = 10;
  localparam int FRAME_CNT_W = 5;
  localparam int PERIOD_W   = 10;
  localparam int CNT_W      = 32;
  localparam int HIST_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int DEF_PAGE_COUNT = 1024;
  localparam int DEF_MAX_FRAMES = 16;

  localparam logic [FRAME_CNT_W-1:0] FRAME_COUNT_RST = 5'd16;
  localparam logic [PERIOD_W-1:0]    TICK_PERIOD_RST = 10'd150;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_CHK,
    ST_TICK,
    ST_SEARCH,
    ST_MIN,
    ST_EVICT,
    ST_REFRD,
    ST_REFWR,
    ST_DONE
  } apr_state_t;

endpackage

// ===== sv/apr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page reference channel
// One beat carries one page reference.
// ----------------------------------------------------------------------------
interface apr_in_if;
  logic                       valid;
  logic                       ready;
  logic [apr_pkg::PAGE_W-1:0] page_number;
  logic                       is_write;

  modport source (output valid, page_number, is_write, input ready);
  modport sink   (input valid, page_number, is_write, output ready);
endinterface

// ===== sv/apr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replacement result channel
// One beat per page reference.
// ----------------------------------------------------------------------------
interface apr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       evicted_valid;
  logic [apr_pkg::PAGE_W-1:0] evicted_page;
  logic                       writeback;
  logic                       tick_done;
  logic [apr_pkg::CNT_W-1:0]  fault_total;
  logic [apr_pkg::CNT_W-1:0]  writeback_total;
  logic [apr_pkg::CNT_W-1:0]  interrupt_total;

  modport source (output valid, hit, evicted_valid, evicted_page, writeback, tick_done,
                  fault_total, writeback_total, interrupt_total, input ready);
  modport sink   (input valid, hit, evicted_valid, evicted_page, writeback, tick_done,
                  fault_total, writeback_total, interrupt_total, output ready);
endinterface

// ===== sv/apr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one register.
// ----------------------------------------------------------------------------
interface apr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [apr_pkg::CFG_IDX_W-1:0]  index;
  logic [apr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/aging_page_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging page replacement core
// 8-bit aging histories per page, load-ordered frame list, saturating totals.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per page reference (page_number, is_write).
//   out_ch : one result beat per reference, in order.
//   cfg_ch : register writes (frame_count, tick_period), always ready; write
//            only while no reference is in flight.
// Steps per reference: a modulo reduction of the page number when it is at or
//   above PAGE_COUNT, a history tick when one falls due (read-modify-write
//   sweep of the history memory, one page a cycle), a lookup scan over the
//   resident frames, and a victim scan on a full miss.
// One reference is in work at a time; the next is taken while a result waits
//   in the output register.
// Reset: the history memory is cleared by a pass over every page, during
//   which in_ch is not ready; configuration returns to 16 frames, period 150.
// Stall: a finished result holds in the output register until taken; the
//   following reference then waits in its final state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aging_page_replacement_core #(
  parameter int PAGE_COUNT = apr_pkg::DEF_PAGE_COUNT,
  parameter int MAX_FRAMES = apr_pkg::DEF_MAX_FRAMES
) (
  input  logic clk,
  input  logic rst_n,
  apr_in_if.sink    in_ch,
  apr_out_if.source out_ch,
  apr_cfg_if.sink   cfg_ch
);
  import apr_pkg::*;

  localparam int PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SW  = $clog2(PAGE_COUNT + 1);
  localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int MW  = PW + PAGE_W + 1;
  localparam int MEM_W = HIST_W + 1;

  // history memory: {ref bit, history}
  logic [MEM_W-1:0] hist_mem [PAGE_COUNT];
  logic [MEM_W-1:0] mem_rdata_r;
  logic [PW-1:0]    mem_ra, mem_wa;
  logic [MEM_W-1:0] mem_wd;
  logic             mem_we;

  logic [PAGE_W-1:0] frame_page_r  [MAX_FRAMES];
  logic              frame_dirty_r [MAX_FRAMES];

  apr_state_t state_r, state_nxt;

  logic [FRAME_CNT_W-1:0] frame_count_r;
  logic [PERIOD_W-1:0]    tick_period_r;
  logic [PERIOD_W-1:0]    since_r;
  logic [CW-1:0]          res_r;
  logic [CNT_W-1:0]       fault_r, wb_cnt_r, intr_r;
  logic [SW-1:0]          sw_r;
  logic [CW-1:0]          i_r;
  logic [3:0]             k_r;
  logic                   pend_r, first_r;
  logic [PW-1:0]          paddr_r;
  logic [FIW-1:0]         pidx_r, victim_r;
  logic [HIST_W-1:0]      best_r;
  logic [PAGE_W-1:0]      page_r;
  logic                   wr_r, hit_r, ev_r, wbk_r, tick_r;
  logic [PAGE_W-1:0]      ev_page_r;

  logic                   out_valid_r;
  logic                   o_hit_r, o_ev_r, o_wb_r, o_tick_r;
  logic [PAGE_W-1:0]      o_evp_r;
  logic [CNT_W-1:0]       o_fault_r, o_wbt_r, o_intr_r;

  logic [CW-1:0]     limit_c;
  logic [PERIOD_W-1:0] period_c;
  logic [MW-1:0]     mod_sub_c;
  logic              mod_ge_c;
  logic [PAGE_W-1:0] cur_frame_c;
  logic              in_acc, tick_issue, min_issue, out_load;
  logic [CW-1:0]     new_idx_c;

  always_comb begin
    if (frame_count_r == '0) begin
      limit_c = CW'(1);
    end else if (7'(frame_count_r) > 7'(MAX_FRAMES)) begin
      limit_c = CW'(MAX_FRAMES);
    end else begin
      limit_c = CW'(frame_count_r);
    end
    period_c    = (tick_period_r == '0) ? PERIOD_W'(1) : tick_period_r;
    mod_sub_c   = MW'(PAGE_COUNT) << k_r;
    mod_ge_c    = MW'(page_r) >= mod_sub_c;
    cur_frame_c = frame_page_r[i_r[FIW-1:0]];
    tick_issue  = sw_r < SW'(PAGE_COUNT);
    min_issue   = i_r < res_r;
    new_idx_c   = ev_r ? res_r - CW'(1) : res_r;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sw_r == SW'(PAGE_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (32'(in_ch.page_number) >= PAGE_COUNT) ? ST_MOD : ST_CHK;
        end
      end
      ST_MOD:    if (k_r == '0) state_nxt = ST_CHK;
      ST_CHK:    state_nxt = (since_r >= period_c) ? ST_TICK : ST_SEARCH;
      ST_TICK:   if (!tick_issue && !pend_r) state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (i_r == res_r) begin
          state_nxt = (res_r >= limit_c) ? ST_MIN : ST_EVICT;
        end else if (cur_frame_c == page_r) begin
          state_nxt = ST_REFRD;
        end
      end
      ST_MIN:    if (!min_issue && !pend_r) state_nxt = ST_EVICT;
      ST_EVICT:  state_nxt = ST_REFRD;
      ST_REFRD:  state_nxt = ST_REFWR;
      ST_REFWR:  state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_ra = PW'(page_r);
    mem_wa = paddr_r;
    mem_wd = '0;
    mem_we = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sw_r[PW-1:0];
      end
      ST_TICK: begin
        mem_ra = sw_r[PW-1:0];
        mem_we = pend_r;
        mem_wd = {1'b0, mem_rdata_r[HIST_W], mem_rdata_r[HIST_W-1:1]};
      end
      ST_MIN:   mem_ra = PW'(cur_frame_c);
      ST_REFWR: begin
        mem_we = 1'b1;
        mem_wa = PW'(page_r);
        mem_wd = {1'b1, mem_rdata_r[HIST_W-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    mem_rdata_r <= hist_mem[mem_ra];
  end

  // frame list
  always_ff @(posedge clk) begin
    if (state_r == ST_EVICT) begin
      for (int j = 0; j < MAX_FRAMES - 1; j++) begin
        if (ev_r && FIW'(j) >= victim_r && CW'(j) != new_idx_c) begin
          frame_page_r[j]  <= frame_page_r[j+1];
          frame_dirty_r[j] <= frame_dirty_r[j+1];
        end
      end
      frame_page_r[new_idx_c[FIW-1:0]]  <= page_r;
      frame_dirty_r[new_idx_c[FIW-1:0]] <= wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      frame_count_r <= FRAME_COUNT_RST;
      tick_period_r <= TICK_PERIOD_RST;
      since_r       <= '0;
      res_r         <= '0;
      fault_r       <= '0;
      wb_cnt_r      <= '0;
      intr_r        <= '0;
      sw_r          <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_FRAME_COUNT: frame_count_r <= cfg_ch.data[FRAME_CNT_W-1:0];
          CFG_TICK_PERIOD: tick_period_r <= cfg_ch.data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: sw_r <= sw_r + SW'(1);
        ST_IDLE: begin
          if (in_acc) begin
            page_r <= in_ch.page_number;
            wr_r   <= in_ch.is_write;
            hit_r  <= 1'b0;
            ev_r   <= 1'b0;
            wbk_r  <= 1'b0;
            tick_r <= 1'b0;
            k_r    <= 4'd9;
          end
        end
        ST_MOD: begin
          if (mod_ge_c) begin
            page_r <= page_r - mod_sub_c[PAGE_W-1:0];
          end
          k_r <= k_r - 4'd1;
        end
        ST_CHK: begin
          i_r <= '0;
          if (since_r >= period_c) begin
            since_r <= PERIOD_W'(1);
            tick_r  <= 1'b1;
            intr_r  <= (intr_r == '1) ? intr_r : intr_r + CNT_W'(1);
            sw_r    <= '0;
            pend_r  <= 1'b0;
          end else begin
            since_r <= since_r + PERIOD_W'(1);
          end
        end
        ST_TICK: begin
          pend_r  <= tick_issue;
          paddr_r <= sw_r[PW-1:0];
          if (tick_issue) begin
            sw_r <= sw_r + SW'(1);
          end
        end
        ST_SEARCH: begin
          if (i_r == res_r) begin
            i_r     <= '0;
            first_r <= 1'b1;
            pend_r  <= 1'b0;
            ev_r    <= (res_r >= limit_c);
          end else if (cur_frame_c == page_r) begin
            hit_r <= 1'b1;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        ST_MIN: begin
          pend_r <= min_issue;
          pidx_r <= i_r[FIW-1:0];
          if (min_issue) begin
            i_r <= i_r + CW'(1);
          end
          if (pend_r) begin
            first_r <= 1'b0;
            if (first_r || mem_rdata_r[HIST_W-1:0] < best_r) begin
              best_r   <= mem_rdata_r[HIST_W-1:0];
              victim_r <= pidx_r;
            end
          end
        end
        ST_EVICT: begin
          fault_r <= (fault_r == '1) ? fault_r : fault_r + CNT_W'(1);
          if (!ev_r) begin
            res_r <= res_r + CW'(1);
          end
          ev_page_r <= frame_page_r[victim_r];
          if (ev_r && frame_dirty_r[victim_r]) begin
            wbk_r    <= 1'b1;
            wb_cnt_r <= (wb_cnt_r == '1) ? wb_cnt_r : wb_cnt_r + CNT_W'(1);
            intr_r   <= (intr_r == '1) ? intr_r : intr_r + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            o_hit_r     <= hit_r;
            o_ev_r      <= ev_r;
            o_evp_r     <= ev_r ? ev_page_r : '0;
            o_wb_r      <= wbk_r;
            o_tick_r    <= tick_r;
            o_fault_r   <= fault_r;
            o_wbt_r     <= wb_cnt_r;
            o_intr_r    <= intr_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = o_hit_r;
  assign out_ch.evicted_valid   = o_ev_r;
  assign out_ch.evicted_page    = o_evp_r;
  assign out_ch.writeback       = o_wb_r;
  assign out_ch.tick_done       = o_tick_r;
  assign out_ch.fault_total     = o_fault_r;
  assign out_ch.writeback_total = o_wbt_r;
  assign out_ch.interrupt_total = o_intr_r;

  `APR_NEVER(a_res_bound, res_r > CW'(MAX_FRAMES), "resident count above frame capacity")
  `APR_ASSERT(a_hit_no_evict, out_valid_r && o_hit_r |-> !o_ev_r && !o_wb_r, "hit with eviction")
  `APR_ASSERT(a_acc_leaves_idle, in_acc |=> state_r != ST_IDLE, "accepted beat not taken up")
  `APR_ASSERT(a_wb_needs_evict, out_valid_r && o_wb_r |-> o_ev_r, "write-back without victim")

endmodule
